FILE: hdl/dws_pkg.sv
// Shared types, register codes and defaults for the diamond window sum unit.
package dws_pkg;

	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;
	localparam int MAX_TIES_DEF = 64;

	localparam int CFG_W   = 9;
	localparam int CFG_IDX = 2;
	localparam int SUM_W   = 32;
	localparam int TIE_W   = 17;
	localparam int POS_W   = 9;
	localparam int CELL_W  = 16;
	localparam int RAD_W   = 8;

	localparam logic [TIE_W-1:0] TIE_SAT = 17'd65536;

	localparam logic [CFG_IDX-1:0] REG_ROWS   = 2'd0;
	localparam logic [CFG_IDX-1:0] REG_COLS   = 2'd1;
	localparam logic [CFG_IDX-1:0] REG_RADIUS = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD,
		S_POS,
		S_ROW,
		S_COL,
		S_DRAIN1,
		S_DRAIN2,
		S_VISIT,
		S_OUT_RD,
		S_OUT_SHOW
	} state_t;

	typedef struct packed {
		logic loading;
		logic pos_start;
		logic row_eval;
		logic col_issue;
		logic dr_next;
		logic visit;
		logic pos_next;
		logic out_start;
		logic out_read;
		logic out_next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_acc;
		logic row_ok;
		logic dr_last;
		logic col_last;
		logic grid_last;
		logic out_taken;
		logic out_last;
	} sts_t;

endpackage

FILE: hdl/diamond_window_sum_argmax_unit.sv
// Loading takes one cell per cycle; the search then evaluates, for each grid position, every
// window row, reads the window cells inside the grid, drains the read pipeline and records the sum.
// Each result is read from the tie list memory, then held in the output register.
// The next grid is taken once the last result has been delivered; throughput is set
// by the single read port of the grid memory. Reset clears control, configuration and
// accumulator state; the grid and tie memories are not cleared and need no clearing pass.
module diamond_window_sum_argmax_unit #(
	parameter int MAX_ROWS = dws_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = dws_pkg::MAX_COLS_DEF,
	parameter int MAX_TIES = dws_pkg::MAX_TIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dws_pkg::CFG_IDX-1:0]       cfg_index,
	input  logic [dws_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [dws_pkg::CELL_W-1:0] cell_value,
	input  logic                              last_cell,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [dws_pkg::SUM_W-1:0]  best_sum,
	output logic [dws_pkg::TIE_W-1:0]         tie_count,
	output logic [dws_pkg::POS_W-1:0]         pos_row,
	output logic [dws_pkg::POS_W-1:0]         pos_col,
	output logic                              last_result
);

	dws_pkg::cmd_t cmd;
	dws_pkg::sts_t sts;

	dws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dws_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_TIES (MAX_TIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_value  (cell_value),
		.last_cell   (last_cell),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.best_sum    (best_sum),
		.tie_count   (tie_count),
		.pos_row     (pos_row),
		.pos_col     (pos_col),
		.last_result (last_result),
		.cmd         (cmd),
		.sts         (sts)
	);

	// No grid request is taken while a result is on offer.
	a_no_load_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	// Every result reports at least one tied position.
	a_tie_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tie_count != '0))
		else $error("result with zero tie count");

	// A taken result that is not the last is followed by a fetch cycle.
	a_fetch_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_result) |=> (!out_valid && in_stall))
		else $error("result fetch gap missing");

	// After the final result the block returns to loading.
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> !in_stall)
		else $error("block did not return to loading");

endmodule

FILE: hdl/dws_ctrl.sv
// Controller state machine sequencing load, window search and result output.
module dws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  dws_pkg::sts_t sts,
	output dws_pkg::cmd_t cmd
);

	dws_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dws_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dws_pkg::S_LOAD: begin
				if (sts.last_acc) state_d = dws_pkg::S_POS;
			end
			dws_pkg::S_POS: state_d = dws_pkg::S_ROW;
			dws_pkg::S_ROW: begin
				if (sts.row_ok) state_d = dws_pkg::S_COL;
				else if (sts.dr_last) state_d = dws_pkg::S_DRAIN1;
			end
			dws_pkg::S_COL: begin
				if (sts.col_last) begin
					state_d = sts.dr_last ? dws_pkg::S_DRAIN1 : dws_pkg::S_ROW;
				end
			end
			dws_pkg::S_DRAIN1: state_d = dws_pkg::S_DRAIN2;
			dws_pkg::S_DRAIN2: state_d = dws_pkg::S_VISIT;
			dws_pkg::S_VISIT: begin
				state_d = sts.grid_last ? dws_pkg::S_OUT_RD : dws_pkg::S_POS;
			end
			dws_pkg::S_OUT_RD: state_d = dws_pkg::S_OUT_SHOW;
			dws_pkg::S_OUT_SHOW: begin
				if (sts.out_taken) begin
					state_d = sts.out_last ? dws_pkg::S_LOAD : dws_pkg::S_OUT_RD;
				end
			end
			default: state_d = dws_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			dws_pkg::S_LOAD: cmd.loading = 1'b1;
			dws_pkg::S_POS: cmd.pos_start = 1'b1;
			dws_pkg::S_ROW: begin
				cmd.row_eval = sts.row_ok;
				cmd.dr_next  = !sts.row_ok;
			end
			dws_pkg::S_COL: begin
				cmd.col_issue = 1'b1;
				cmd.dr_next   = sts.col_last;
			end
			dws_pkg::S_DRAIN1, dws_pkg::S_DRAIN2: begin
			end
			dws_pkg::S_VISIT: begin
				cmd.visit     = 1'b1;
				cmd.pos_next  = !sts.grid_last;
				cmd.out_start = sts.grid_last;
			end
			dws_pkg::S_OUT_RD: cmd.out_read = 1'b1;
			dws_pkg::S_OUT_SHOW: begin
				cmd.finish   = sts.out_taken && sts.out_last;
				cmd.out_next = sts.out_taken && !sts.out_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hdl/dws_dp.sv
// Datapath: configuration, grid memory, window accumulation, tie list and output register.
module dws_dp #(
	parameter int MAX_ROWS = dws_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = dws_pkg::MAX_COLS_DEF,
	parameter int MAX_TIES = dws_pkg::MAX_TIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dws_pkg::CFG_IDX-1:0]       cfg_index,
	input  logic [dws_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [dws_pkg::CELL_W-1:0] cell_value,
	input  logic                              last_cell,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [dws_pkg::SUM_W-1:0]  best_sum,
	output logic [dws_pkg::TIE_W-1:0]         tie_count,
	output logic [dws_pkg::POS_W-1:0]         pos_row,
	output logic [dws_pkg::POS_W-1:0]         pos_col,
	output logic                              last_result,
	input  dws_pkg::cmd_t                     cmd,
	output dws_pkg::sts_t                     sts
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int DW    = (RW > CW) ? RW : CW;
	localparam int SW    = ((DW > dws_pkg::RAD_W) ? DW : dws_pkg::RAD_W) + 2;
	localparam int TW    = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;

	logic [dws_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [dws_pkg::RAD_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= dws_pkg::CFG_W'(1);
			cols_cfg_q <= dws_pkg::CFG_W'(1);
			radius_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dws_pkg::REG_ROWS:   rows_cfg_q <= cfg_data;
				dws_pkg::REG_COLS:   cols_cfg_q <= cfg_data;
				dws_pkg::REG_RADIUS: radius_q   <= cfg_data[dws_pkg::RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic [RCW-1:0] rows_eff;
	logic [CCW-1:0] cols_eff;
	logic [LW-1:0]  cap;

	always_comb begin
		if (rows_cfg_q == '0) rows_eff = RCW'(1);
		else if (32'(rows_cfg_q) > 32'(MAX_ROWS)) rows_eff = RCW'(MAX_ROWS);
		else rows_eff = RCW'(rows_cfg_q);
		if (cols_cfg_q == '0) cols_eff = CCW'(1);
		else if (32'(cols_cfg_q) > 32'(MAX_COLS)) cols_eff = CCW'(MAX_COLS);
		else cols_eff = CCW'(cols_cfg_q);
		cap = LW'(rows_eff * cols_eff);
	end

	// Loading
	logic          in_acc;
	logic [LW-1:0] load_q;

	assign in_stall = !cmd.loading;
	assign in_acc   = in_valid && cmd.loading;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
		end else if (cmd.finish) begin
			load_q <= '0;
		end else if (in_acc && (load_q < cap)) begin
			load_q <= load_q + LW'(1);
		end
	end

	// Position and window counters
	logic [RW-1:0] r_q;
	logic [CW-1:0] k_q, c, cc_q, hi_q;
	logic          dir_q, first_q;
	logic signed [SW-1:0] dr_q, d_s, r_s, c_s, rr, absdr, w, lo_s, hi_s;
	logic signed [SW-1:0] lo_c, hi_c, rows_s, cols_m1_s, zero_s;
	logic [AW-1:0] base_q, addr_s1;

	always_comb begin
		c         = dir_q ? CW'(cols_eff - CCW'(1) - CCW'(k_q)) : k_q;
		d_s       = SW'(radius_q);
		r_s       = SW'(r_q);
		c_s       = SW'(c);
		rows_s    = SW'(rows_eff);
		cols_m1_s = SW'(cols_eff) - SW'(1);
		zero_s    = '0;
		rr        = r_s + dr_q;
		absdr     = dr_q[SW-1] ? -dr_q : dr_q;
		w         = d_s - absdr;
		lo_s      = c_s - w;
		hi_s      = c_s + w;
		lo_c      = (lo_s < zero_s) ? zero_s : lo_s;
		hi_c      = (hi_s > cols_m1_s) ? cols_m1_s : hi_s;
	end

	assign sts.last_acc  = in_acc && last_cell;
	assign sts.row_ok    = !rr[SW-1] && (rr < rows_s) && (lo_c <= hi_c);
	assign sts.dr_last   = (dr_q == d_s);
	assign sts.col_last  = (cc_q == hi_q);
	assign sts.grid_last = (RCW'(r_q) == rows_eff - RCW'(1)) &&
	                       (CCW'(k_q) == cols_eff - CCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			k_q     <= '0;
			dir_q   <= 1'b0;
			dr_q    <= '0;
			cc_q    <= '0;
			first_q <= 1'b1;
		end else begin
			if (cmd.pos_start) dr_q <= -d_s;
			else if (cmd.dr_next) dr_q <= dr_q + SW'(1);
			if (cmd.row_eval) cc_q <= lo_c[CW-1:0];
			else if (cmd.col_issue) cc_q <= cc_q + CW'(1);
			if (cmd.visit) first_q <= 1'b0;
			if (cmd.pos_next) begin
				if (CCW'(k_q) == cols_eff - CCW'(1)) begin
					k_q   <= '0;
					r_q   <= r_q + RW'(1);
					dir_q <= !dir_q;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			if (cmd.finish) begin
				r_q     <= '0;
				k_q     <= '0;
				dir_q   <= 1'b0;
				first_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_eval) begin
			base_q <= AW'(rr[RW-1:0] * cols_eff);
			hi_q   <= hi_c[CW-1:0];
		end
	end

	// Grid memory and read pipeline
	logic signed [dws_pkg::CELL_W-1:0] grid_mem [DEPTH];
	logic signed [dws_pkg::CELL_W-1:0] data_s2;
	logic vld_s1, vld_s2;
	logic signed [dws_pkg::SUM_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (in_acc && (load_q < cap)) grid_mem[load_q[AW-1:0]] <= cell_value;
		data_s2 <= grid_mem[addr_s1];
		addr_s1 <= base_q + AW'(cc_q);
	end

	// Cells not loaded in this load count as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= cmd.col_issue;
			vld_s2 <= vld_s1 && (LW'(addr_s1) < load_q);
			if (cmd.pos_start) acc_q <= '0;
			else if (vld_s2) acc_q <= acc_q + dws_pkg::SUM_W'(data_s2);
		end
	end

	// Best sum and tie list
	logic signed [dws_pkg::SUM_W-1:0] best_q;
	logic [dws_pkg::TIE_W-1:0]        tie_q, n_res;
	logic [RW+CW-1:0]                 tie_mem [MAX_TIES];
	logic [RW+CW-1:0]                 posr_q;
	logic [TW-1:0]                    oi_q;
	logic                             better, equal, out_vld_q;

	assign better = first_q || (acc_q > best_q);
	assign equal  = (acc_q == best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			tie_q  <= '0;
		end else if (cmd.visit) begin
			if (better) begin
				best_q <= acc_q;
				tie_q  <= dws_pkg::TIE_W'(1);
			end else if (equal && (tie_q < dws_pkg::TIE_SAT)) begin
				tie_q <= tie_q + dws_pkg::TIE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.visit) begin
			if (better) tie_mem[0] <= {r_q, c};
			else if (equal && (tie_q < dws_pkg::TIE_W'(MAX_TIES)))
				tie_mem[tie_q[TW-1:0]] <= {r_q, c};
		end
		if (cmd.out_read) posr_q <= tie_mem[oi_q];
	end

	assign n_res = (tie_q < dws_pkg::TIE_W'(MAX_TIES)) ? tie_q : dws_pkg::TIE_W'(MAX_TIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oi_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.out_start) oi_q <= '0;
			else if (cmd.out_next) oi_q <= oi_q + TW'(1);
			if (cmd.out_read) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	assign sts.out_taken = out_vld_q && !out_stall;
	assign sts.out_last  = (dws_pkg::TIE_W'(oi_q) + dws_pkg::TIE_W'(1) == n_res);

	assign out_valid   = out_vld_q;
	assign best_sum    = best_q;
	assign tie_count   = tie_q;
	assign pos_row     = dws_pkg::POS_W'(RCW'(posr_q[RW+CW-1:CW]) + RCW'(1));
	assign pos_col     = dws_pkg::POS_W'(CCW'(posr_q[CW-1:0]) + CCW'(1));
	assign last_result = sts.out_last;

endmodule

FILE: tb/tb_diamond_window_sum_argmax_unit.sv
// Testbench for the diamond window sum unit: directed and random grids checked against a predictor.
module tb_diamond_window_sum_argmax_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCH_LIMIT = 3000000;

	typedef struct {
		logic signed [dws_pkg::SUM_W-1:0] best;
		logic [dws_pkg::TIE_W-1:0]        ties;
		logic [dws_pkg::POS_W-1:0]        row;
		logic [dws_pkg::POS_W-1:0]        col;
		logic                             last;
	} peak_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [dws_pkg::CFG_IDX-1:0] cfg_index = dws_pkg::REG_ROWS;
	logic [dws_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [dws_pkg::CELL_W-1:0] cell_value = '0;
	logic last_cell = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [dws_pkg::SUM_W-1:0] best_sum;
	logic [dws_pkg::TIE_W-1:0] tie_count;
	logic [dws_pkg::POS_W-1:0] pos_row;
	logic [dws_pkg::POS_W-1:0] pos_col;
	logic last_result;

	// Predictor state.
	logic [dws_pkg::CFG_W-1:0] rows_reg = 9'd1;
	logic [dws_pkg::CFG_W-1:0] cols_reg = 9'd1;
	logic [dws_pkg::RAD_W-1:0] radius_reg = '0;
	logic signed [dws_pkg::CELL_W-1:0] grid_mem [0:65535];
	int load_count = 0;
	peak_t peak_queue [$];

	int errors = 0;
	int cells_sent = 0;
	int grids_sent = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;
	int idle_cycles = 0;

	diamond_window_sum_argmax_unit uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [dws_pkg::CFG_W-1:0] v);
		if (v == 0) return 1;
		return (v > 256) ? 256 : int'(v);
	endfunction

	task automatic search_grid();
		int rows, cols, d, c, w, lo, hi, n;
		int signed acc, best;
		int ties;
		logic [dws_pkg::POS_W-1:0] tr [0:63];
		logic [dws_pkg::POS_W-1:0] tc [0:63];
		peak_t p;
		rows = eff_dim(rows_reg);
		cols = eff_dim(cols_reg);
		d = int'(radius_reg);
		best = 0;
		ties = 0;
		for (int r = 0; r < rows; r++) begin
			for (int k = 0; k < cols; k++) begin
				c = r[0] ? cols - 1 - k : k;
				acc = 0;
				for (int dr = -d; dr <= d; dr++) begin
					if (r + dr < 0 || r + dr >= rows) continue;
					w = d - (dr < 0 ? -dr : dr);
					lo = (c - w < 0) ? 0 : c - w;
					hi = (c + w > cols - 1) ? cols - 1 : c + w;
					for (int cc = lo; cc <= hi; cc++)
						if ((r + dr) * cols + cc < load_count)
							acc += int'(grid_mem[(r + dr) * cols + cc]);
				end
				if ((r == 0 && k == 0) || acc > best) begin
					best = acc;
					ties = 1;
					tr[0] = dws_pkg::POS_W'(r + 1);
					tc[0] = dws_pkg::POS_W'(c + 1);
				end else if (acc == best) begin
					if (ties < 64) begin
						tr[ties] = dws_pkg::POS_W'(r + 1);
						tc[ties] = dws_pkg::POS_W'(c + 1);
					end
					if (ties < 65536) ties++;
				end
			end
		end
		n = (ties < 64) ? ties : 64;
		for (int i = 0; i < n; i++) begin
			p.best = best;
			p.ties = dws_pkg::TIE_W'(ties);
			p.row = tr[i];
			p.col = tc[i];
			p.last = (i == n - 1);
			peak_queue.push_back(p);
		end
		load_count = 0;
	endtask

	task automatic write_reg(input logic [dws_pkg::CFG_IDX-1:0] idx,
			input logic [dws_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			dws_pkg::REG_ROWS: rows_reg = val;
			dws_pkg::REG_COLS: cols_reg = val;
			dws_pkg::REG_RADIUS: radius_reg = val[dws_pkg::RAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (peak_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_grid(input logic [dws_pkg::CFG_W-1:0] r,
			input logic [dws_pkg::CFG_W-1:0] c, input logic [dws_pkg::CFG_W-1:0] rad);
		wait_drained();
		write_reg(dws_pkg::REG_ROWS, r);
		write_reg(dws_pkg::REG_COLS, c);
		write_reg(dws_pkg::REG_RADIUS, rad);
		cfg_we <= 1'b0;
	endtask

	task automatic send_cell(input logic signed [dws_pkg::CELL_W-1:0] v, input logic fin);
		int gap;
		int cap;
		in_valid <= 1'b1;
		cell_value <= v;
		last_cell <= fin;
		do @(posedge clk); while (in_stall);
		cap = eff_dim(rows_reg) * eff_dim(cols_reg);
		if (load_count < cap) begin
			grid_mem[load_count] = v;
			load_count++;
		end
		cells_sent++;
		if (fin) begin
			grids_sent++;
			search_grid();
		end
		gap = quiet_send ? 0 :
			(($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 30));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver stall, with an optional long hold-off counted here.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (quiet_recv) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 9) < 3) || ($urandom_range(0, 49) == 0);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			results_seen++;
			if (peak_queue.size() == 0) begin
				$error("result with nothing expected: sum %0d row %0d col %0d",
					best_sum, pos_row, pos_col);
				errors++;
			end else begin
				peak_t e;
				e = peak_queue.pop_front();
				if (best_sum !== e.best) begin
					$error("best_sum expected %0d actual %0d", e.best, best_sum);
					errors++;
				end
				if (tie_count !== e.ties) begin
					$error("tie_count expected %0d actual %0d", e.ties, tie_count);
					errors++;
				end
				if (pos_row !== e.row) begin
					$error("pos_row expected %0d actual %0d", e.row, pos_row);
					errors++;
				end
				if (pos_col !== e.col) begin
					$error("pos_col expected %0d actual %0d", e.col, pos_col);
					errors++;
				end
				if (last_result !== e.last) begin
					$error("last_result expected %0d actual %0d", e.last, last_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", WATCH_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_default_single();
		send_cell(-16'sd32768, 1'b1);
		send_cell(16'sd32767, 1'b1);
	endtask

	task automatic test_register_limits();
		// Zero acts as one, values past the maximum act as the maximum.
		set_grid(9'd0, 9'd0, 9'd3);
		send_cell(16'sh5555, 1'b1);
		set_grid(9'd511, 9'd1, 9'd255);
		send_cell(16'sd32767, 1'b0);
		send_cell(16'sd32767, 1'b0);
		send_cell(-16'sd1, 1'b1);
		set_grid(9'd1, 9'd300, 9'd255);
		send_cell(-16'sd32768, 1'b0);
		send_cell(16'sd7, 1'b1);
	endtask

	task automatic test_extra_and_short();
		set_grid(9'd2, 9'd2, 9'd0);
		for (int i = 0; i < 6; i++) send_cell(16'(i * 1000 - 2000), i == 5);
		set_grid(9'd3, 9'd4, 9'd1);
		send_cell(16'sd5, 1'b0);
		send_cell(16'sd5, 1'b1);
	endtask

	task automatic test_tie_saturation();
		// Whole maximum grid ties at zero: full count, first 64 positions listed.
		set_grid(9'd256, 9'd256, 9'd0);
		send_cell(16'sd0, 1'b1);
	endtask

	task automatic test_backpressure();
		set_grid(9'd8, 9'd8, 9'd0);
		wait_drained();
		hold_left = 3000;
		send_cell(16'sd0, 1'b1);
		send_cell(-16'sd4, 1'b0);
		send_cell(16'sd9, 1'b1);
		// The sender now waits for every result before going on.
		wait_drained();
	endtask

	task automatic test_random();
		int rows, cols, cnt, mode;
		logic signed [dws_pkg::CELL_W-1:0] v;
		while (cells_sent < 225) begin
			rows = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 6);
			cols = (rows > 8) ? $urandom_range(0, 2) : $urandom_range(1, 6);
			set_grid(dws_pkg::CFG_W'(rows), dws_pkg::CFG_W'(cols),
				dws_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, 4)));
			quiet_send = ($urandom_range(0, 3) == 0);
			quiet_recv = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 2);
			cnt = eff_dim(dws_pkg::CFG_W'(rows)) * eff_dim(dws_pkg::CFG_W'(cols));
			if (cnt > 8) cnt = $urandom_range(1, 8);
			else if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt + 3);
			for (int i = 0; i < cnt; i++) begin
				if (mode == 0) v = dws_pkg::CELL_W'($urandom_range(0, 65535));
				else if (mode == 1) v = dws_pkg::CELL_W'(int'($urandom_range(0, 2)) - 1);
				else v = ($urandom_range(0, 1) ? -16'sd32768 : 16'sd32767);
				send_cell(v, i == cnt - 1);
			end
		end
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_single();
		test_register_limits();
		test_extra_and_short();
		test_tie_saturation();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (50) @(posedge clk);
		$display("Covered %0d cells in %0d grids, %0d results checked, %0d mismatches.",
			cells_sent, grids_sent, results_seen, errors);
		if (errors == 0 && peak_queue.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
